FILE: sv/jse_pkg.sv
// Shared types and constants for the JSON string escaper.
// Holds the item descriptor passed from the classifier to the emitter.
// No dependencies.
package jse_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_CTRL_LAST = 8'h1F;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;

	// what the emitter has to produce for one input byte
	typedef enum logic [1:0] {
		K_PLAIN,	// byte as is
		K_PAIR,		// backslash, then ch
		K_UNI,		// \u00XX from ch
		K_END		// closing quote
	} kind_t;

	typedef struct packed {
		logic       open;	// opening quote goes first
		kind_t      kind;
		logic [7:0] ch;
	} desc_t;

	localparam int DESC_W = $bits(desc_t);

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10)
			r = CH_ZERO + {4'd0, nib};
		else
			r = CH_UPPER_A + {4'd0, nib} - 8'd10;
		return r;
	endfunction

endpackage

FILE: sv/json_string_escaper_unit.sv
// Top level of the JSON string escaper: classifier, descriptor queue, emitter.
// Depends on jse_pkg, jse_classify, jse_queue, jse_emit.
//
// Takes one string byte per item on s_* (byte 0 ends the string) and emits the quoted,
// escaped JSON text one byte per item on m_*, with m_tuser marking the closing quote
// and m_tlast marking the last byte produced for an input byte. The emitter puts out
// one byte per cycle while m_tready does not stall it. An input byte produces 1 byte for
// ordinary text or a closing quote, 2 for a two-character escape, 6 for a \u00XX escape,
// plus 1 for the first byte of a string (opening quote), so an empty string's terminator
// produces 2. Plain text runs at one byte per cycle when the output is not stalled. The
// first output item is valid after the queue entry is written on acceptance and the
// output register is loaded when the emitter next steps. The queue of
// QUEUE_DEPTH descriptors lets the input keep flowing while the emitter works through
// an escape; once it is full, s_tready drops.
module json_string_escaper_unit #(
	parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,	// [7:0] char_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,	// [7:0] out_byte
	output logic       m_tuser,	// [0] string_done
	output logic       m_tlast	// run_last
);
	import jse_pkg::*;

	logic  push_valid, push_ready, pop_valid, pop;
	desc_t push_desc, pop_desc;

	jse_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_desc  (push_desc),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_desc   (pop_desc)
	);

	jse_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

FILE: sv/jse_classify.sv
// Front end: accepts string bytes, tracks the open quote, classifies each byte.
// Produces a jse_pkg::desc_t per item for the descriptor queue.
// Depends on jse_pkg.
module jse_classify (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,	// [7:0] char_byte
	output logic           push_valid,
	input  logic           push_ready,
	output jse_pkg::desc_t push_desc
);
	import jse_pkg::*;

	logic  quote_opened_q;
	kind_t kind;
	logic [7:0] ch;

	always_comb begin
		kind = K_PLAIN;
		ch   = s_tdata;
		case (s_tdata) inside
			CH_NUL: begin
				kind = K_END;
			end
			CH_QUOTE, CH_BSLASH: begin
				kind = K_PAIR;
			end
			CH_BS: begin
				kind = K_PAIR;
				ch   = CH_LOW_B;
			end
			CH_FF: begin
				kind = K_PAIR;
				ch   = CH_LOW_F;
			end
			CH_LF: begin
				kind = K_PAIR;
				ch   = CH_LOW_N;
			end
			CH_CR: begin
				kind = K_PAIR;
				ch   = CH_LOW_R;
			end
			CH_TAB: begin
				kind = K_PAIR;
				ch   = CH_LOW_T;
			end
			[8'h01:CH_CTRL_LAST]: begin
				kind = K_UNI;
			end
			default: begin
				kind = K_PLAIN;
			end
		endcase
	end

	assign push_valid     = s_tvalid;
	assign s_tready       = push_ready;
	assign push_desc.open = ~quote_opened_q;
	assign push_desc.kind = kind;
	assign push_desc.ch   = ch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_opened_q <= 1'b0;
		end else if (s_tvalid && push_ready) begin
			quote_opened_q <= (kind != K_END);
		end
	end

endmodule

FILE: sv/jse_queue.sv
// Short descriptor queue between classifier and emitter.
// Circular buffer with occupancy count; head entry read combinationally.
// Depends on jse_pkg.
module jse_queue #(
	parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  jse_pkg::desc_t push_desc,
	output logic           pop_valid,
	input  logic           pop,
	output jse_pkg::desc_t pop_desc
);
	import jse_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	desc_t         entry_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_desc   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/jse_emit.sv
// Back end: steps through the output bytes of the head descriptor.
// One byte per cycle into the output register while it is not stalled; pops the queue on the last byte.
// Depends on jse_pkg.
module jse_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop,
	input  jse_pkg::desc_t pop_desc,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,	// [7:0] out_byte
	output logic           m_tuser,	// [0] string_done
	output logic           m_tlast	// run_last
);
	import jse_pkg::*;

	logic [2:0] idx_q;
	logic [2:0] body_len, last_idx, pos;
	logic [7:0] byte_out;
	logic       at_last, load, step;
	logic       m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [7:0] m_tdata_q;

	always_comb begin
		case (pop_desc.kind)
			K_PAIR:  body_len = 3'd2;
			K_UNI:   body_len = 3'd6;
			default: body_len = 3'd1;
		endcase
	end

	assign last_idx = body_len - 3'd1 + {2'd0, pop_desc.open};
	assign pos      = idx_q - {2'd0, pop_desc.open};
	assign at_last  = (idx_q == last_idx);

	always_comb begin
		byte_out = pop_desc.ch;
		if (pop_desc.open && idx_q == 3'd0) begin
			byte_out = CH_QUOTE;
		end else begin
			case (pop_desc.kind)
				K_END:   byte_out = CH_QUOTE;
				K_PAIR:  byte_out = (pos == 3'd0) ? CH_BSLASH : pop_desc.ch;
				K_UNI: begin
					case (pos)
						3'd0:    byte_out = CH_BSLASH;
						3'd1:    byte_out = CH_LOW_U;
						3'd2:    byte_out = CH_ZERO;
						3'd3:    byte_out = CH_ZERO;
						3'd4:    byte_out = hex_digit(pop_desc.ch[7:4]);
						default: byte_out = hex_digit(pop_desc.ch[3:0]);
					endcase
				end
				default: byte_out = pop_desc.ch;
			endcase
		end
	end

	assign load = !m_tvalid_q || m_tready;
	assign step = load && pop_valid;
	assign pop  = step && at_last;

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata_q <= byte_out;
			m_tuser_q <= at_last && (pop_desc.kind == K_END);
			m_tlast_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid_q <= pop_valid;
			end
			if (step) begin
				idx_q <= at_last ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	a_done_is_quote: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata == CH_QUOTE)
		else $error("string_done on a byte other than a closing quote");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> idx_q <= last_idx)
		else $error("emitter step index beyond end of run");

	a_idx_reset_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 3'd0)
		else $error("step index not cleared after run");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output register changed while stalled");

endmodule
